>>> design/svr_pkg.sv
// Types and constants of the stepper velocity ramp generator.
// No dependencies; imported by stepper_velocity_ramp_top.
package svr_pkg;

   localparam int RPM_W       = 12;
   localparam int NOW_W       = 32;
   localparam int PERIOD_W    = 16;
   localparam int POS_W       = 32;
   localparam int VEL_W       = 16;
   localparam int STEP_W      = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 2;
   localparam int MPS_W       = 10;
   localparam int MPS_X60_W   = 16;

   localparam int RPM_MAX     = 1200;
   localparam int RPM_MIN     = 600;
   localparam int CLAMP_W     = 11;

   // Shared divider: dividend / quotient register width and iteration counter
   localparam int DIV_W       = 48;
   localparam int CNT_W       = 6;
   localparam int START_NUM   = 30000000;
   localparam int START_NUM_W = 25;

   localparam int SLOW_PERIOD = 1000;
   localparam int SLOW_OFFSET = 3;
   localparam int FAST_PERIOD = 400;
   localparam int COARSE_STEP = 10;
   localparam int SEC_PER_MIN = 60;

   localparam logic [PERIOD_W-1:0]  START_PERIOD_RST = 16'd1000;
   localparam logic [NOW_W-1:0]     HOLD_US_RST      = 32'd2000000;
   localparam logic [MPS_X60_W-1:0] MPS_X60_RST      = 16'd6000;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_PULSE   = 2'd1,
      ACT_MEASURE = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_PERIOD = 2'd0,
      CSR_HOLD_US      = 2'd1,
      CSR_DIRECTION    = 2'd2,
      CSR_MEASURES     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FIN_START,
      ST_UPD_PERIOD,
      ST_UPD_FLAGS,
      ST_MUL,
      ST_FIN_VEL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [RPM_W-1:0] rpm;
      logic [NOW_W-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic                       step_level;
      logic [PERIOD_W-1:0]        period_us;
      logic                       running;
      logic signed [POS_W-1:0]    position;
      logic signed [VEL_W-1:0]    velocity_rpm;
   } rsp_type;

endpackage

>>> design/stepper_velocity_ramp_top.sv
// Stepper trapezoidal velocity ramp generator, top level.
// Depends on svr_pkg (types, constants, state and action codes).
//
//   channel   handshake                  payload
//   req       req_valid / req_ready      req_data  (svr_pkg::req_type)
//   rsp       rsp_valid / rsp_ready      rsp_data  (svr_pkg::rsp_type)
//   csr       csr_we, csr_addr           csr_wdata (write only, no wait)
//
// Start items run the shared restoring divider, then the target step.
// Pulse items that run the full-step update go through the period, flag and
// multiply steps and then the divider for the velocity. All other items go
// straight to the response. req_ready is high only in the idle state;
// a finished item waits in the rsp register while the next one is taken.
// Reset is synchronous and restores the register and ramp state at once.
module stepper_velocity_ramp_top
   import svr_pkg::*;
#(
   parameter int STEPS_PER_REV = 200
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DVS_W = $clog2(RPM_MAX * STEPS_PER_REV + 1);
   localparam logic [DVS_W-1:0] SPR_V     = DVS_W'(STEPS_PER_REV);
   localparam logic [DVS_W-1:0] TWO_SPR_V = DVS_W'(2 * STEPS_PER_REV);

   // configuration
   logic [PERIOD_W-1:0]  start_period_ff;
   logic [NOW_W-1:0]     hold_us_ff;
   logic                 direction_ff;
   logic [MPS_X60_W-1:0] mps_x60_ff;

   // ramp state
   state_type            state_ff, state_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [PERIOD_W-1:0]  target_ff, target_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 reached_ff, reached_in;
   logic                 holding_ff, holding_in;
   logic [NOW_W-1:0]     hold_start_ff, hold_start_in;
   logic                 half_ff, half_in;
   logic                 pending_ff, pending_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     last_pos_ff, last_pos_in;
   logic                 run_ff, run_in;
   logic                 pin_ff, pin_in;
   logic [VEL_W-1:0]     vel_ff, vel_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 is_start_ff, is_start_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // datapath payload
   logic [NOW_W-1:0]     now_ff, now_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [POS_W-1:0]     mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   rsp_type              rsp_ff, rsp_in;

   // combinational helpers
   logic [CLAMP_W-1:0]   rpm_c;
   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       diff;
   logic                 ge;
   logic signed [PERIOD_W+1:0] np;
   logic [POS_W-1:0]     delta;
   logic [NOW_W-1:0]     held;
   logic                 hit_target;
   logic [PERIOD_W-1:0]  quot;
   logic [DIV_W-1:0]     prod;
   logic                 rsp_load;
   logic                 full_update;

   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign full_update = run_ff && half_ff && pending_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (action_type'(req_data.action) == ACT_START) begin
                  state_in = ST_DIVIDE;
               end else if (action_type'(req_data.action) == ACT_PULSE && full_update) begin
                  state_in = ST_UPD_PERIOD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = is_start_ff ? ST_FIN_START : ST_FIN_VEL;
            end
         end
         ST_FIN_START:  state_in = ST_DONE;
         ST_UPD_PERIOD: state_in = ST_UPD_FLAGS;
         ST_UPD_FLAGS:  state_in = ST_MUL;
         ST_MUL:        state_in = ST_DIVIDE;
         ST_FIN_VEL:    state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   // shared arithmetic
   always_comb begin
      priority if (req_data.rpm > RPM_W'(RPM_MAX)) begin
         rpm_c = CLAMP_W'(RPM_MAX);
      end else if (req_data.rpm < RPM_W'(RPM_MIN)) begin
         rpm_c = CLAMP_W'(RPM_MIN);
      end else begin
         rpm_c = req_data.rpm[CLAMP_W-1:0];
      end

      shifted = {rem_ff, div_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});

      np = reached_ff ? ($signed({2'b00, period_ff}) + $signed({13'd0, step_ff}))
                      : ($signed({2'b00, period_ff}) - $signed({13'd0, step_ff}));

      delta      = pos_ff - last_pos_ff;
      held       = now_ff - hold_start_ff;
      hit_target = (period_ff == target_ff) && !reached_ff;
      quot       = div_ff[PERIOD_W-1:0];
      prod       = DIV_W'(mag_ff) * DIV_W'(mps_x60_ff);
   end

   // datapath next values
   always_comb begin
      period_in     = period_ff;
      target_in     = target_ff;
      step_in       = step_ff;
      reached_in    = reached_ff;
      holding_in    = holding_ff;
      hold_start_in = hold_start_ff;
      half_in       = half_ff;
      pending_in    = pending_ff;
      pos_in        = pos_ff;
      last_pos_in   = last_pos_ff;
      run_in        = run_ff;
      pin_in        = pin_ff;
      vel_in        = vel_ff;
      is_start_in   = is_start_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (action_type'(req_data.action))
                  ACT_START: begin
                     period_in     = start_period_ff;
                     step_in       = STEP_W'(1);
                     reached_in    = 1'b0;
                     holding_in    = 1'b0;
                     hold_start_in = req_data.now_us;
                     half_in       = 1'b1;
                     last_pos_in   = pos_ff;
                     run_in        = 1'b1;
                     // divide 30e6 by rpm * steps, dividend pre-aligned to the top
                     is_start_in   = 1'b1;
                     dvs_in        = DVS_W'(rpm_c) * SPR_V;
                     div_in        = DIV_W'(START_NUM) << (DIV_W - START_NUM_W);
                     rem_in        = '0;
                     cnt_in        = CNT_W'(START_NUM_W);
                  end
                  ACT_PULSE: begin
                     if (run_ff) begin
                        pin_in  = ~pin_ff;
                        pos_in  = direction_ff ? pos_ff + POS_W'(1) : pos_ff - POS_W'(1);
                        half_in = ~half_ff;
                        now_in  = req_data.now_us;
                     end
                  end
                  ACT_MEASURE: pending_in = 1'b1;
                  ACT_NOP: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            div_in = {div_ff[DIV_W-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_FIN_START: begin
            priority if (quot >= PERIOD_W'(SLOW_PERIOD)) begin
               target_in = quot - PERIOD_W'(SLOW_OFFSET);
            end else if (quot != '0) begin
               target_in = quot - PERIOD_W'(1);
            end else begin
               target_in = '0;
            end
         end
         ST_UPD_PERIOD: begin
            pending_in = 1'b0;
            if (!holding_ff) begin
               priority if (np <= $signed({2'b00, target_ff})) begin
                  period_in = target_ff;
               end else if (np > $signed({2'b00, {PERIOD_W{1'b1}}})) begin
                  period_in = '1;
               end else begin
                  period_in = np[PERIOD_W-1:0];
               end
            end
         end
         ST_UPD_FLAGS: begin
            step_in = (period_ff > PERIOD_W'(FAST_PERIOD)) ? STEP_W'(COARSE_STEP)
                                                           : STEP_W'(1);
            if (hit_target) begin
               reached_in    = 1'b1;
               holding_in    = 1'b1;
               hold_start_in = now_ff;
               step_in       = STEP_W'(1);
            end else if (holding_ff && (held > hold_us_ff)) begin
               holding_in = 1'b0;
            end
            if (period_ff >= start_period_ff) begin
               run_in = 1'b0;
            end
            neg_in      = delta[POS_W-1];
            mag_in      = delta[POS_W-1] ? (~delta + POS_W'(1)) : delta;
            last_pos_in = pos_ff;
         end
         ST_MUL: begin
            is_start_in = 1'b0;
            div_in      = prod;
            dvs_in      = TWO_SPR_V;
            rem_in      = '0;
            cnt_in      = CNT_W'(DIV_W);
         end
         ST_FIN_VEL: begin
            if (!neg_ff) begin
               vel_in = (|div_ff[DIV_W-1:VEL_W-1]) ? {1'b0, {(VEL_W-1){1'b1}}}
                                                  : div_ff[VEL_W-1:0];
            end else begin
               vel_in = (|div_ff[DIV_W-1:VEL_W-1]) ? {1'b1, {(VEL_W-1){1'b0}}}
                                                  : (~div_ff[VEL_W-1:0] + VEL_W'(1));
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in         = 1'b1;
               rsp_in.step_level    = pin_ff;
               rsp_in.period_us     = period_ff;
               rsp_in.running       = run_ff;
               rsp_in.position      = $signed(pos_ff);
               rsp_in.velocity_rpm  = $signed(vel_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_period_ff <= START_PERIOD_RST;
         hold_us_ff      <= HOLD_US_RST;
         direction_ff    <= 1'b0;
         mps_x60_ff      <= MPS_X60_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_START_PERIOD: start_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_HOLD_US:      hold_us_ff      <= csr_wdata[NOW_W-1:0];
            CSR_DIRECTION:    direction_ff    <= csr_wdata[0];
            CSR_MEASURES: begin
               mps_x60_ff <= MPS_X60_W'(csr_wdata[MPS_W-1:0]) * MPS_X60_W'(SEC_PER_MIN);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         period_ff     <= '0;
         target_ff     <= '0;
         step_ff       <= STEP_W'(1);
         reached_ff    <= 1'b0;
         holding_ff    <= 1'b0;
         hold_start_ff <= '0;
         half_ff       <= 1'b1;
         pending_ff    <= 1'b0;
         pos_ff        <= '0;
         last_pos_ff   <= '0;
         run_ff        <= 1'b0;
         pin_ff        <= 1'b0;
         vel_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         is_start_ff   <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         period_ff     <= period_in;
         target_ff     <= target_in;
         step_ff       <= step_in;
         reached_ff    <= reached_in;
         holding_ff    <= holding_in;
         hold_start_ff <= hold_start_in;
         half_ff       <= half_in;
         pending_ff    <= pending_in;
         pos_ff        <= pos_in;
         last_pos_ff   <= last_pos_in;
         run_ff        <= run_in;
         pin_ff        <= pin_in;
         vel_ff        <= vel_in;
         rsp_valid_ff  <= rsp_valid_in;
         is_start_ff   <= is_start_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> sim/tb_stepper_velocity_ramp_top.sv
// Self-checking testbench for stepper_velocity_ramp_top: drives start, pulse and
// measure items, predicts every status item and checks it field by field.
// Depends on svr_pkg and the stepper_velocity_ramp_top RTL.
module tb_stepper_velocity_ramp_top;
   timeunit 1ns;
   timeprecision 1ps;
   import svr_pkg::*;

   localparam int STEPS_PER_REV = 200;
   localparam int LIMIT_NS      = 30_000_000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted register settings
   logic [PERIOD_W-1:0] cfg_start_period = START_PERIOD_RST;
   logic [NOW_W-1:0]    cfg_hold_us      = HOLD_US_RST;
   logic                cfg_dir          = 1'b0;
   logic [MPS_W-1:0]    cfg_mps          = 10'd100;

   // predicted ramp state, at its reset values
   logic [PERIOD_W-1:0]     ramp_period   = '0;
   logic [PERIOD_W-1:0]     ramp_target   = '0;
   logic [STEP_W-1:0]       ramp_step     = 5'd1;
   logic                    ramp_reached  = 1'b0;
   logic                    ramp_holding  = 1'b0;
   logic [NOW_W-1:0]        ramp_hold_t0  = '0;
   logic                    ramp_half     = 1'b1;
   logic                    ramp_meas_due = 1'b0;
   logic [POS_W-1:0]        ramp_pos      = '0;
   logic [POS_W-1:0]        ramp_pos_mark = '0;
   logic                    ramp_running  = 1'b0;
   logic                    ramp_pin      = 1'b0;
   logic signed [VEL_W-1:0] ramp_vel      = '0;

   rsp_type          status_due[$];
   int               err_count     = 0;
   bit               gaps_on       = 1'b1;
   int               holdoff_cycles = 0;
   int               now_stride    = 400;
   logic [NOW_W-1:0] now_cnt       = '0;

   stepper_velocity_ramp_top #(
      .STEPS_PER_REV(STEPS_PER_REV)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL stepper_velocity_ramp_top");
      $finish;
   end

   // Advance the ramp state by one item and return the status it reports.
   function automatic rsp_type next_ramp_status(req_type item);
      rsp_type          st;
      int               rpm_c;
      int               quot;
      int               offs;
      longint           np;
      longint           delta;
      longint           vel;
      logic [NOW_W-1:0] held;
      case (item.action)
         ACT_START: begin
            rpm_c = int'(item.rpm);
            if (rpm_c > RPM_MAX) rpm_c = RPM_MAX;
            if (rpm_c < RPM_MIN) rpm_c = RPM_MIN;
            quot = START_NUM / (rpm_c * STEPS_PER_REV);
            offs = (quot >= SLOW_PERIOD) ? SLOW_OFFSET : 1;
            quot = (quot >= offs) ? quot - offs : 0;
            ramp_target   = (quot > 65535) ? 16'hFFFF : quot[PERIOD_W-1:0];
            ramp_period   = cfg_start_period;
            ramp_step     = 5'd1;
            ramp_reached  = 1'b0;
            ramp_holding  = 1'b0;
            ramp_hold_t0  = item.now_us;
            ramp_half     = 1'b1;
            ramp_pos_mark = ramp_pos;
            ramp_running  = 1'b1;
         end
         ACT_PULSE: begin
            if (ramp_running) begin
               ramp_pin  = ~ramp_pin;
               ramp_pos  = cfg_dir ? ramp_pos + POS_W'(1) : ramp_pos - POS_W'(1);
               ramp_half = ~ramp_half;
               // full step with a measure tick waiting: move the period
               if (!ramp_half && ramp_meas_due) begin
                  if (!ramp_holding) begin
                     np = ramp_reached ? longint'(ramp_period) + longint'(ramp_step)
                                       : longint'(ramp_period) - longint'(ramp_step);
                     if (np <= longint'(ramp_target)) np = longint'(ramp_target);
                     if (np > 65535) np = 65535;
                     ramp_period = np[PERIOD_W-1:0];
                  end
                  ramp_meas_due = 1'b0;
                  ramp_step = (ramp_period > FAST_PERIOD) ? STEP_W'(COARSE_STEP)
                                                          : STEP_W'(1);
                  if (ramp_period == ramp_target && !ramp_reached) begin
                     ramp_reached = 1'b1;
                     ramp_holding = 1'b1;
                     ramp_hold_t0 = item.now_us;
                     ramp_step    = 5'd1;
                  end
                  held = item.now_us - ramp_hold_t0;
                  if (ramp_holding && held > cfg_hold_us) ramp_holding = 1'b0;
                  if (ramp_period >= cfg_start_period) ramp_running = 1'b0;
                  delta = longint'($signed(ramp_pos - ramp_pos_mark));
                  vel = delta * longint'(cfg_mps) * SEC_PER_MIN / STEPS_PER_REV / 2;
                  if (vel > 32767) vel = 32767;
                  if (vel < -32768) vel = -32768;
                  ramp_vel      = vel[VEL_W-1:0];
                  ramp_pos_mark = ramp_pos;
               end
            end
         end
         ACT_MEASURE: ramp_meas_due = 1'b1;
         default: ;
      endcase
      st.step_level   = ramp_pin;
      st.period_us    = ramp_period;
      st.running      = ramp_running;
      st.position     = ramp_pos;
      st.velocity_rpm = ramp_vel;
      return st;
   endfunction

   function automatic logic [RPM_W-1:0] pick_rpm();
      case ($urandom_range(0, 3))
         0: return RPM_W'($urandom_range(0, 4095));
         1: return RPM_W'($urandom_range(RPM_MIN, RPM_MAX));
         2: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         default: return RPM_W'($urandom_range(600, 660));
      endcase
   endfunction

   task automatic report_field(string field, longint want, longint got);
      err_count++;
      if (err_count <= 100) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   task automatic check_status(rsp_type got);
      rsp_type want;
      if (status_due.size() == 0) begin
         err_count++;
         $display("%0t ns: status item with none expected, expected nothing, actual %p",
                  $time, got);
      end else begin
         want = status_due.pop_front();
         if (got.step_level !== want.step_level)
            report_field("step_level", longint'(want.step_level),
                         longint'(got.step_level));
         if (got.period_us !== want.period_us)
            report_field("period_us", longint'(want.period_us), longint'(got.period_us));
         if (got.running !== want.running)
            report_field("running", longint'(want.running), longint'(got.running));
         if (got.position !== want.position)
            report_field("position", longint'(want.position), longint'(got.position));
         if (got.velocity_rpm !== want.velocity_rpm)
            report_field("velocity_rpm", longint'(want.velocity_rpm),
                         longint'(got.velocity_rpm));
      end
   endtask

   // Receiver: stall at random before each item when gaps are on, or for a long
   // hold-off when one is requested.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_cycles > 0) begin
            stall = holdoff_cycles;
            holdoff_cycles = 0;
         end else begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_status(rsp_data);
      end
   end

   // Offer one item; valid stays high when the next item follows at once.
   task automatic send_item(req_type item);
      int gap;
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      status_due.push_back(next_ramp_status(item));
   endtask

   task automatic offer_item(action_type act, logic [RPM_W-1:0] rpm);
      req_type item;
      now_cnt += $urandom_range(0, now_stride);
      item.action = act;
      item.rpm    = rpm;
      item.now_us = now_cnt;
      send_item(item);
   endtask

   // measure tick followed by both half steps of one full step
   task automatic offer_full_step();
      offer_item(ACT_MEASURE, RPM_W'($urandom_range(0, 4095)));
      offer_item(ACT_PULSE, RPM_W'($urandom_range(0, 4095)));
      offer_item(ACT_PULSE, RPM_W'($urandom_range(0, 4095)));
   endtask

   task automatic wait_all_status();
      req_valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_START_PERIOD: cfg_start_period = val[PERIOD_W-1:0];
         CSR_HOLD_US:      cfg_hold_us      = val;
         CSR_DIRECTION:    cfg_dir          = val[0];
         CSR_MEASURES:     cfg_mps          = val[MPS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic test_directed_cases();
      now_cnt = 32'hFFFF_FE00;
      send_item(req_type'{ACT_NOP, 12'hFFF, 32'hFFFF_FFFF});
      offer_item(ACT_PULSE, 12'h000);
      offer_item(ACT_MEASURE, 12'hFFF);
      send_item(req_type'{ACT_START, 12'h000, 32'h0000_0000});
      offer_item(ACT_PULSE, 12'h555);
      offer_item(ACT_PULSE, 12'hAAA);
      offer_full_step();
      // restart while running, with a measure tick still waiting
      offer_item(ACT_MEASURE, 12'h000);
      offer_item(ACT_START, 12'hFFF);
      offer_item(ACT_PULSE, 12'h000);
      offer_item(ACT_PULSE, 12'hFFF);
      wait_all_status();
      // target above the start period ends the run at the first update
      csr_write(CSR_START_PERIOD, 100);
      csr_write(CSR_HOLD_US, 0);
      csr_write(CSR_DIRECTION, 1);
      csr_write(CSR_MEASURES, 0);
      offer_item(ACT_START, 12'd1200);
      offer_full_step();
      offer_item(ACT_PULSE, 12'd0);
      wait_all_status();
      csr_write(CSR_START_PERIOD, 1);
      csr_write(CSR_HOLD_US, 32'hFFFF_FFFF);
      csr_write(CSR_MEASURES, 1000);
      offer_item(ACT_START, 12'd700);
      offer_full_step();
      wait_all_status();
      csr_write(CSR_START_PERIOD, 16'hFFFF);
      offer_item(ACT_START, 12'd1199);
      offer_full_step();
      offer_item(ACT_NOP, 12'd0);
      wait_all_status();
   endtask

   // many half steps between measurements drive the rpm past both limits
   task automatic test_velocity_saturation();
      csr_write(CSR_DIRECTION, 1);
      csr_write(CSR_MEASURES, 1000);
      offer_item(ACT_START, 12'd900);
      repeat (225) offer_item(ACT_PULSE, RPM_W'($urandom_range(0, 4095)));
      offer_full_step();
      wait_all_status();
      csr_write(CSR_DIRECTION, 0);
      offer_item(ACT_START, 12'd1100);
      repeat (225) offer_item(ACT_PULSE, RPM_W'($urandom_range(0, 4095)));
      offer_full_step();
      wait_all_status();
   endtask

   // hold the receiver off long enough that the block stalls its input
   task automatic test_backpressure();
      gaps_on = 1'b0;
      holdoff_cycles = 400;
      repeat (8) offer_full_step();
      wait_all_status();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_ramps();
      int      r;
      int      n;
      req_type noise;
      now_cnt = $urandom;
      for (int ph = 0; ph < 4; ph++) begin
         wait_all_status();
         case ($urandom_range(0, 7))
            0:       csr_write(CSR_START_PERIOD, 1);
            1:       csr_write(CSR_START_PERIOD, 65535);
            2:       csr_write(CSR_START_PERIOD, $urandom_range(1, 130));
            6, 7:    csr_write(CSR_START_PERIOD, $urandom_range(401, 520));
            default: csr_write(CSR_START_PERIOD, $urandom_range(250, 275));
         endcase
         case ($urandom_range(0, 4))
            0:       csr_write(CSR_HOLD_US, 0);
            1:       csr_write(CSR_HOLD_US, 32'hFFFF_FFFF);
            2:       csr_write(CSR_HOLD_US, $urandom);
            default: csr_write(CSR_HOLD_US, $urandom_range(0, 4000));
         endcase
         csr_write(CSR_DIRECTION, $urandom_range(0, 1));
         case ($urandom_range(0, 5))
            0:       csr_write(CSR_MEASURES, 0);
            1:       csr_write(CSR_MEASURES, 1);
            2:       csr_write(CSR_MEASURES, 1000);
            default: csr_write(CSR_MEASURES, $urandom_range(1, 1000));
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         offer_item(ACT_START, pick_rpm());
         n = 1;
         while (n < 40) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               offer_item(ACT_START, pick_rpm());
               n++;
            end else if (r < 13) begin
               noise.action = 2'($urandom_range(0, 3));
               noise.rpm    = RPM_W'($urandom_range(0, 4095));
               noise.now_us = $urandom;
               send_item(noise);
               n++;
            end else if (r < 15) begin
               wait_all_status();
            end else begin
               offer_full_step();
               n += 3;
            end
         end
      end
      wait_all_status();
      gaps_on = 1'b1;
   endtask

   // ramp down to the target, hold, then turn back up
   task automatic test_period_saturation();
      int guard;
      gaps_on    = 1'b0;
      now_stride = 50;
      csr_write(CSR_START_PERIOD, 252);
      csr_write(CSR_HOLD_US, 0);
      csr_write(CSR_MEASURES, 1000);
      offer_item(ACT_START, 12'd600);
      wait_all_status();
      csr_write(CSR_START_PERIOD, 16'hFFFF);
      guard = 0;
      while (ramp_running && guard < 12) begin
         offer_full_step();
         guard++;
      end
      wait_all_status();
      gaps_on    = 1'b1;
      now_stride = 400;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_velocity_saturation();
      test_backpressure();
      test_random_ramps();
      test_period_saturation();
      wait_all_status();
      repeat (100) @(posedge clock);
      if (err_count == 0) begin
         $display("PASS stepper_velocity_ramp_top");
      end else begin
         $display("FAIL stepper_velocity_ramp_top");
      end
      $finish;
   end

endmodule
